// File: src/pfcs_pkg.sv
// ----------------------------------------------------------------------------
// pfcs_pkg: shared definitions for the parallel flash command sequencer
// Operation codes, result kinds, flash command bytes, register defaults
// and the job descriptor that the front end hands to the back end.
// ----------------------------------------------------------------------------
package pfcs_pkg;

	localparam int ADDR_WIDTH_DEF = 19;
	localparam int NUM_REGS       = 6;
	localparam int REG_WIDTH      = 16;
	localparam int CFG_IDX_WIDTH  = 3;
	localparam int QUEUE_DEPTH    = 4;
	localparam int STEP_WIDTH     = 3;

	// operation codes on the input side
	localparam logic [2:0] OP_READ   = 3'd0;
	localparam logic [2:0] OP_PROG   = 3'd1;
	localparam logic [2:0] OP_SECTOR = 3'd2;
	localparam logic [2:0] OP_CHIP   = 3'd3;
	localparam logic [2:0] OP_ID     = 3'd4;
	localparam logic [2:0] OP_SAMPLE = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_PROG_POLL   = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_PROG_OK     = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_SECTOR_POLL = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_SECTOR_OK   = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_CHIP_POLL   = 3'd4;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_CHIP_OK     = 3'd5;

	localparam logic [REG_WIDTH-1:0] REG_RESET [NUM_REGS] = '{
		16'd100, 16'd50, 16'd2000, 16'd1000, 16'd2000, 16'd2000
	};

	// unlock cycles and command bytes
	localparam logic [15:0] UNLOCK_ADDR1 = 16'h5555;
	localparam logic [15:0] UNLOCK_ADDR2 = 16'h2AAA;
	localparam logic [7:0]  UNLOCK_DATA1 = 8'hAA;
	localparam logic [7:0]  UNLOCK_DATA2 = 8'h55;
	localparam logic [7:0]  CMD_PROGRAM  = 8'hA0;
	localparam logic [7:0]  CMD_ERASE    = 8'h80;
	localparam logic [7:0]  CMD_SECTOR   = 8'h30;
	localparam logic [7:0]  CMD_CHIP     = 8'h10;
	localparam logic [7:0]  CMD_ID_ENTRY = 8'h90;
	localparam logic [7:0]  CMD_ID_EXIT  = 8'hF0;

	typedef enum logic [1:0] {
		KIND_WRITE    = 2'd0,
		KIND_READ_REQ = 2'd1,
		KIND_DATA     = 2'd2,
		KIND_DONE     = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_READ   = 3'd1,
		PH_POLL   = 3'd2,
		PH_ID_MAN = 3'd3,
		PH_ID_DEV = 3'd4
	} phase_t;

	// result sequences the back end knows how to play out
	typedef enum logic [2:0] {
		SEQ_DONE          = 3'd0,
		SEQ_READ_REQ      = 3'd1,
		SEQ_DATA_DONE     = 3'd2,
		SEQ_DATA_READ_REQ = 3'd3,
		SEQ_PROGRAM       = 3'd4,
		SEQ_ERASE         = 3'd5,
		SEQ_ID_START      = 3'd6,
		SEQ_ID_DEV        = 3'd7
	} seq_t;

	typedef struct packed {
		seq_t       seq;
		logic [7:0] data;
		logic       tail_done;
		logic       success;
	} job_t;

endpackage

// File: src/pfcs_front.sv
// ----------------------------------------------------------------------------
// pfcs_front: command and sample front end
// Holds the configuration registers and the sequencer state, takes one
// transaction per cycle while the queue has room, making jobs for the back end.
// ----------------------------------------------------------------------------
module pfcs_front #(
	parameter int ADDR_WIDTH = pfcs_pkg::ADDR_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [pfcs_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [pfcs_pkg::REG_WIDTH-1:0]      cfg_data,
	input  logic                                push,
	input  logic [2:0]                          operation,
	input  logic [ADDR_WIDTH-1:0]               address,
	input  logic [7:0]                          data_byte,
	input  logic [7:0]                          byte_count,
	input  logic                                q_full,
	output logic                                q_push,
	output pfcs_pkg::job_t                      q_job,
	output logic [ADDR_WIDTH-1:0]               q_addr
);
	import pfcs_pkg::*;

	logic [REG_WIDTH-1:0]  regs_q [NUM_REGS];
	phase_t                phase_q, phase_d;
	logic [2:0]            active_q, active_d;
	logic                  exp_bit_q, exp_bit_d;
	logic [REG_WIDTH-1:0]  poll_count_q, poll_count_d;
	logic [ADDR_WIDTH-1:0] next_addr_q, next_addr_d;
	logic [7:0]            reads_left_q, reads_left_d;

	logic                  accept;
	logic                  is_sample;
	logic                  is_cmd;
	logic                  bit_match;
	logic [REG_WIDTH-1:0]  pc_inc;
	logic [REG_WIDTH-1:0]  poll_lim;
	logic [REG_WIDTH-1:0]  ok_lim;
	logic [REG_WIDTH-1:0]  start_lim;
	logic [REG_WIDTH-1:0]  start_ok;
	logic [7:0]            rl_dec;
	logic                  poll_give_up;

	function automatic logic [REG_WIDTH-1:0] pick_limit(
		input logic [2:0]           op,
		input logic [REG_WIDTH-1:0] lim_prog,
		input logic [REG_WIDTH-1:0] lim_sector,
		input logic [REG_WIDTH-1:0] lim_chip
	);
		logic [REG_WIDTH-1:0] res;
		priority if (op == OP_PROG) begin
			res = lim_prog;
		end else if (op == OP_SECTOR) begin
			res = lim_sector;
		end else begin
			res = lim_chip;
		end
		return res;
	endfunction

	assign accept       = push && !q_full;
	assign is_sample    = (operation == OP_SAMPLE);
	assign is_cmd       = (operation <= OP_ID);
	assign bit_match    = (data_byte[7] == exp_bit_q);
	assign pc_inc       = (poll_count_q == '1) ? poll_count_q : poll_count_q + 16'd1;
	assign rl_dec       = reads_left_q - 8'd1;
	assign poll_lim     = pick_limit(active_q, regs_q[CFG_PROG_POLL],
		regs_q[CFG_SECTOR_POLL], regs_q[CFG_CHIP_POLL]);
	assign ok_lim       = pick_limit(active_q, regs_q[CFG_PROG_OK],
		regs_q[CFG_SECTOR_OK], regs_q[CFG_CHIP_OK]);
	assign start_lim    = pick_limit(operation, regs_q[CFG_PROG_POLL],
		regs_q[CFG_SECTOR_POLL], regs_q[CFG_CHIP_POLL]);
	assign start_ok     = pick_limit(operation, regs_q[CFG_PROG_OK],
		regs_q[CFG_SECTOR_OK], regs_q[CFG_CHIP_OK]);
	assign poll_give_up = (pc_inc >= poll_lim);

	// next state
	always_comb begin
		phase_d      = phase_q;
		active_d     = active_q;
		exp_bit_d    = exp_bit_q;
		poll_count_d = poll_count_q;
		next_addr_d  = next_addr_q;
		reads_left_d = reads_left_q;
		if (accept) begin
			if (is_sample) begin
				unique case (phase_q)
					PH_READ: begin
						next_addr_d  = next_addr_q + ADDR_WIDTH'(1);
						reads_left_d = rl_dec;
						if (rl_dec == 8'd0) begin
							phase_d = PH_IDLE;
						end
					end
					PH_POLL: begin
						if (bit_match) begin
							phase_d = PH_IDLE;
						end else begin
							poll_count_d = pc_inc;
							if (poll_give_up) begin
								phase_d = PH_IDLE;
							end
						end
					end
					PH_ID_MAN: phase_d = PH_ID_DEV;
					PH_ID_DEV: phase_d = PH_IDLE;
					default: ;
				endcase
			end else if (is_cmd && phase_q == PH_IDLE) begin
				active_d = operation;
				priority case (operation)
					OP_READ: begin
						if (byte_count != 8'd0) begin
							next_addr_d  = address;
							reads_left_d = byte_count;
							phase_d      = PH_READ;
						end
					end
					OP_PROG, OP_SECTOR, OP_CHIP: begin
						exp_bit_d    = (operation == OP_PROG) ? data_byte[7] : 1'b1;
						poll_count_d = '0;
						phase_d      = (start_lim == '0) ? PH_IDLE : PH_POLL;
					end
					default: phase_d = PH_ID_MAN;
				endcase
			end
		end
	end

	// job for the back end
	always_comb begin
		q_push          = 1'b0;
		q_job.seq       = SEQ_DONE;
		q_job.data      = data_byte;
		q_job.tail_done = 1'b0;
		q_job.success   = 1'b1;
		q_addr          = address;
		if (accept) begin
			if (is_sample) begin
				unique case (phase_q)
					PH_READ: begin
						q_push    = 1'b1;
						q_job.seq = (rl_dec == 8'd0) ? SEQ_DATA_DONE : SEQ_DATA_READ_REQ;
						q_addr    = next_addr_q;
					end
					PH_POLL: begin
						if (bit_match) begin
							q_push        = 1'b1;
							q_job.success = (poll_count_q < ok_lim);
						end else if (poll_give_up) begin
							q_push        = 1'b1;
							q_job.success = (pc_inc < ok_lim);
						end
					end
					PH_ID_MAN: begin
						// manufacturer byte read at 0, then request at 1
						q_push    = 1'b1;
						q_job.seq = SEQ_DATA_READ_REQ;
						q_addr    = '0;
					end
					PH_ID_DEV: begin
						q_push    = 1'b1;
						q_job.seq = SEQ_ID_DEV;
						q_addr    = ADDR_WIDTH'(1);
					end
					default: ;
				endcase
			end else if (is_cmd && phase_q == PH_IDLE) begin
				q_push = 1'b1;
				priority case (operation)
					OP_READ: begin
						q_job.seq = (byte_count == 8'd0) ? SEQ_DONE : SEQ_READ_REQ;
					end
					OP_PROG: begin
						q_job.seq       = SEQ_PROGRAM;
						q_job.tail_done = (start_lim == '0);
						q_job.success   = (start_ok != '0);
					end
					OP_SECTOR: begin
						q_job.seq       = SEQ_ERASE;
						q_job.data      = CMD_SECTOR;
						q_job.tail_done = (start_lim == '0);
						q_job.success   = (start_ok != '0);
					end
					OP_CHIP: begin
						q_job.seq       = SEQ_ERASE;
						q_job.data      = CMD_CHIP;
						q_job.tail_done = (start_lim == '0);
						q_job.success   = (start_ok != '0);
						q_addr          = ADDR_WIDTH'(UNLOCK_ADDR1);
					end
					default: begin
						q_job.seq = SEQ_ID_START;
						q_addr    = '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= REG_RESET[i];
			end
		end else if (cfg_write && cfg_index < CFG_IDX_WIDTH'(NUM_REGS)) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			active_q     <= OP_READ;
			exp_bit_q    <= 1'b0;
			poll_count_q <= '0;
			next_addr_q  <= '0;
			reads_left_q <= '0;
		end else begin
			phase_q      <= phase_d;
			active_q     <= active_d;
			exp_bit_q    <= exp_bit_d;
			poll_count_q <= poll_count_d;
			next_addr_q  <= next_addr_d;
			reads_left_q <= reads_left_d;
		end
	end

endmodule

// File: src/pfcs_queue.sv
// ----------------------------------------------------------------------------
// pfcs_queue: job queue between front and back end
// Small first-in first-out store of job descriptors and their addresses.
// ----------------------------------------------------------------------------
module pfcs_queue #(
	parameter int ADDR_WIDTH = pfcs_pkg::ADDR_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pfcs_pkg::job_t        push_job,
	input  logic [ADDR_WIDTH-1:0] push_addr,
	input  logic                  pop,
	output logic                  full,
	output logic                  empty,
	output pfcs_pkg::job_t        head_job,
	output logic [ADDR_WIDTH-1:0] head_addr
);
	import pfcs_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	job_t                  job_mem [QUEUE_DEPTH];
	logic [ADDR_WIDTH-1:0] addr_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]        count_q;

	assign full      = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign head_job  = job_mem[rd_ptr_q];
	assign head_addr = addr_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			job_mem[wr_ptr_q]  <= push_job;
			addr_mem[wr_ptr_q] <= push_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (PTR_W+1)'(1);
				default: ;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job queue read while empty");

endmodule

// File: src/pfcs_back.sv
// ----------------------------------------------------------------------------
// pfcs_back: bus cycle back end
// Plays out the job at the head of the queue one result per cycle into
// the output register while that register is free or being popped.
// ----------------------------------------------------------------------------
module pfcs_back #(
	parameter int ADDR_WIDTH = pfcs_pkg::ADDR_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  pfcs_pkg::job_t        head_job,
	input  logic [ADDR_WIDTH-1:0] head_addr,
	output logic                  q_pop,
	input  logic                  pop,
	output logic                  empty,
	output logic [1:0]            cycle_kind,
	output logic [ADDR_WIDTH-1:0] bus_address,
	output logic [7:0]            bus_data,
	output logic                  success,
	output logic                  last
);
	import pfcs_pkg::*;

	logic                  out_valid_q;
	logic [STEP_WIDTH-1:0] step_q;
	logic [STEP_WIDTH-1:0] step_m1;
	kind_t                 kind_q;
	logic [ADDR_WIDTH-1:0] addr_q;
	logic [7:0]            data_q;
	logic                  ok_q;
	logic                  last_q;

	kind_t                 r_kind;
	logic [ADDR_WIDTH-1:0] r_addr;
	logic [7:0]            r_data;
	logic                  r_ok;
	logic                  r_last;
	logic                  advance;

	// address and data of one unlock write, position 0 to 2
	function automatic logic [23:0] unlock_word(input logic [1:0] pos, input logic [7:0] cmd);
		logic [23:0] w;
		unique case (pos)
			2'd0:    w = {UNLOCK_ADDR1, UNLOCK_DATA1};
			2'd1:    w = {UNLOCK_ADDR2, UNLOCK_DATA2};
			default: w = {UNLOCK_ADDR1, cmd};
		endcase
		return w;
	endfunction

	assign step_m1 = step_q - STEP_WIDTH'(1);

	always_comb begin
		r_kind = KIND_WRITE;
		r_addr = '0;
		r_data = '0;
		r_ok   = 1'b0;
		r_last = 1'b0;
		unique case (head_job.seq)
			SEQ_DONE: begin
				r_kind = KIND_DONE;
				r_ok   = head_job.success;
				r_last = 1'b1;
			end
			SEQ_READ_REQ: begin
				r_kind = KIND_READ_REQ;
				r_addr = head_addr;
				r_last = 1'b1;
			end
			SEQ_DATA_DONE, SEQ_DATA_READ_REQ: begin
				if (step_q == '0) begin
					r_kind = KIND_DATA;
					r_addr = head_addr;
					r_data = head_job.data;
				end else if (head_job.seq == SEQ_DATA_DONE) begin
					r_kind = KIND_DONE;
					r_ok   = head_job.success;
					r_last = 1'b1;
				end else begin
					r_kind = KIND_READ_REQ;
					r_addr = head_addr + ADDR_WIDTH'(1);
					r_last = 1'b1;
				end
			end
			SEQ_PROGRAM, SEQ_ERASE: begin
				if (step_q < STEP_WIDTH'(3)) begin
					r_addr = ADDR_WIDTH'(unlock_word(step_q[1:0],
						(head_job.seq == SEQ_PROGRAM) ? CMD_PROGRAM : CMD_ERASE) >> 8);
					r_data = 8'(unlock_word(step_q[1:0], CMD_ERASE));
					if (step_q == STEP_WIDTH'(2)) begin
						r_data = (head_job.seq == SEQ_PROGRAM) ? CMD_PROGRAM : CMD_ERASE;
					end
				end else if (head_job.seq == SEQ_ERASE && step_q == STEP_WIDTH'(3)) begin
					r_addr = ADDR_WIDTH'(UNLOCK_ADDR1);
					r_data = UNLOCK_DATA1;
				end else if (head_job.seq == SEQ_ERASE && step_q == STEP_WIDTH'(4)) begin
					r_addr = ADDR_WIDTH'(UNLOCK_ADDR2);
					r_data = UNLOCK_DATA2;
				end else if ((head_job.seq == SEQ_PROGRAM && step_q == STEP_WIDTH'(3)) ||
					(head_job.seq == SEQ_ERASE && step_q == STEP_WIDTH'(5))) begin
					// the addressed write: program byte, or sector / chip erase command
					r_addr = head_addr;
					r_data = head_job.data;
				end else begin
					r_last = 1'b1;
					if (head_job.tail_done) begin
						r_kind = KIND_DONE;
						r_ok   = head_job.success;
					end else begin
						r_kind = KIND_READ_REQ;
						r_addr = head_addr;
					end
				end
			end
			SEQ_ID_START: begin
				if (step_q < STEP_WIDTH'(3)) begin
					r_addr = ADDR_WIDTH'(unlock_word(step_q[1:0], CMD_ID_ENTRY) >> 8);
					r_data = 8'(unlock_word(step_q[1:0], CMD_ID_ENTRY));
				end else begin
					r_kind = KIND_READ_REQ;
					r_addr = head_addr;
					r_last = 1'b1;
				end
			end
			SEQ_ID_DEV: begin
				if (step_q == '0) begin
					r_kind = KIND_DATA;
					r_addr = head_addr;
					r_data = head_job.data;
				end else if (step_q < STEP_WIDTH'(4)) begin
					// software id exit
					r_addr = ADDR_WIDTH'(unlock_word(step_m1[1:0], CMD_ID_EXIT) >> 8);
					r_data = 8'(unlock_word(step_m1[1:0], CMD_ID_EXIT));
				end else begin
					r_kind = KIND_DONE;
					r_ok   = head_job.success;
					r_last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign advance = !q_empty && (!out_valid_q || pop);
	assign q_pop   = advance && r_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				step_q      <= r_last ? '0 : step_q + STEP_WIDTH'(1);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q <= r_kind;
			addr_q <= r_addr;
			data_q <= r_data;
			ok_q   <= r_ok;
			last_q <= r_last;
		end
	end

	assign empty       = !out_valid_q;
	assign cycle_kind  = kind_q;
	assign bus_address = addr_q;
	assign bus_data    = data_q;
	assign success     = ok_q;
	assign last        = last_q;

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_DONE) |-> last_q)
		else $error("done result not marked last");

	a_step_restart: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (step_q == '0))
		else $error("step counter not cleared after finishing a job");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_WIDTH'(6))
		else $error("step counter beyond longest sequence");

endmodule

// File: src/parallel_flash_command_sequencer.sv
// ----------------------------------------------------------------------------
// parallel_flash_command_sequencer: parallel flash command sequencer
// Turns flash commands and sampled data bytes into bus cycles, using the
// unlock write sequence and data bit 7 polling.
// ----------------------------------------------------------------------------
// Commands (read burst, byte program, sector erase, chip erase, read id) and
// data samples enter through a queue-style port and are accepted at up to one
// transaction per clock while the internal job queue (four entries) has room;
// a command arriving while a command is under way, a sample while idle, and
// unused codes are swallowed without results. Each accepted transaction that
// yields results is classified in the same cycle and becomes one job, played out
// by the back end as one result per clock unless the consumer stalls; a job makes
// one to seven results (seven for an erase): bus write, read request, returned
// data or done. In a consumer stall, results wait in an output register and new
// input fills the job queue. The user must write the poll and ok limits via the
// configuration port while no command is in progress; the block does not check.
module parallel_flash_command_sequencer #(
	parameter int ADDR_WIDTH = pfcs_pkg::ADDR_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration writes
	input  logic                               cfg_write,
	input  logic [pfcs_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [pfcs_pkg::REG_WIDTH-1:0]     cfg_data,
	// command and sample transactions
	input  logic                               push,
	output logic                               full,
	input  logic [2:0]                         operation,
	input  logic [ADDR_WIDTH-1:0]              address,
	input  logic [7:0]                         data_byte,
	input  logic [7:0]                         byte_count,
	// result transactions
	output logic                               empty,
	input  logic                               pop,
	output logic [1:0]                         cycle_kind,
	output logic [ADDR_WIDTH-1:0]              bus_address,
	output logic [7:0]                         bus_data,
	output logic                               success,
	output logic                               last
);
	import pfcs_pkg::*;

	// front to queue
	logic                  f_push;
	job_t                  f_job;
	logic [ADDR_WIDTH-1:0] f_addr;
	// queue to back
	logic                  q_full;
	logic                  q_empty;
	logic                  q_pop;
	job_t                  q_head_job;
	logic [ADDR_WIDTH-1:0] q_head_addr;

	// input side stalls only when the job queue has no free entry
	assign full = q_full;

	pfcs_front #(
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.operation  (operation),
		.address    (address),
		.data_byte  (data_byte),
		.byte_count (byte_count),
		.q_full     (q_full),
		.q_push     (f_push),
		.q_job      (f_job),
		.q_addr     (f_addr)
	);

	// decouples classification from bus cycle generation
	pfcs_queue #(
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_job  (f_job),
		.push_addr (f_addr),
		.pop       (q_pop),
		.full      (q_full),
		.empty     (q_empty),
		.head_job  (q_head_job),
		.head_addr (q_head_addr)
	);

	pfcs_back #(
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.head_job    (q_head_job),
		.head_addr   (q_head_addr),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.cycle_kind  (cycle_kind),
		.bus_address (bus_address),
		.bus_data    (bus_data),
		.success     (success),
		.last        (last)
	);

endmodule

// File: bench/pfcs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pfcs_checker: bus cycle checker for the parallel flash command sequencer
// Watches the configuration, command and result ports, works out the bus
// cycles that each accepted transaction must cause and compares every
// result transaction, field by field, with the oldest cycle still owed.
// ----------------------------------------------------------------------------
module pfcs_checker #(
	parameter int ADDR_WIDTH = pfcs_pkg::ADDR_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [pfcs_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [pfcs_pkg::REG_WIDTH-1:0]     cfg_data,
	input  logic                               push,
	input  logic                               full,
	input  logic [2:0]                         operation,
	input  logic [ADDR_WIDTH-1:0]              address,
	input  logic [7:0]                         data_byte,
	input  logic [7:0]                         byte_count,
	input  logic                               empty,
	input  logic                               pop,
	input  logic [1:0]                         cycle_kind,
	input  logic [ADDR_WIDTH-1:0]              bus_address,
	input  logic [7:0]                         bus_data,
	input  logic                               success,
	input  logic                               last,
	output int                                 mismatches,
	output int                                 outstanding,
	output int                                 compared,
	output logic                               busy
);
	import pfcs_pkg::*;

	localparam logic [ADDR_WIDTH-1:0] ID_MAN_ADDR = '0;
	localparam logic [ADDR_WIDTH-1:0] ID_DEV_ADDR = ADDR_WIDTH'(1);
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		kind_t                 kind;
		logic [ADDR_WIDTH-1:0] addr;
		logic [7:0]            data;
		logic                  ok;
		logic                  fin;
	} bus_cycle_t;

	bus_cycle_t owed_cycles[$];
	bus_cycle_t new_cycles[$];
	bus_cycle_t head;

	logic [REG_WIDTH-1:0]  limits [NUM_REGS];
	phase_t                phase_now;
	logic [2:0]            cmd_now;
	logic                  want_top;
	logic [15:0]           polls;
	logic [ADDR_WIDTH-1:0] read_ptr;
	logic [7:0]            reads_todo;

	task automatic report_mismatch(input string what, input longint got, input longint wanted);
		if (mismatches < PRINT_CAP)
			$display("%0t: mismatch on %s, got %0h wanted %0h", $time, what, got, wanted);
		mismatches++;
	endtask

	task automatic add_cycle(input kind_t k, input logic [ADDR_WIDTH-1:0] a,
			input logic [7:0] d, input logic ok);
		bus_cycle_t c;
		c.kind = k;
		c.addr = a;
		c.data = d;
		c.ok   = ok;
		c.fin  = 1'b0;
		new_cycles.push_back(c);
	endtask

	task automatic send_unlock(input logic [7:0] cmd);
		add_cycle(KIND_WRITE, ADDR_WIDTH'(UNLOCK_ADDR1), UNLOCK_DATA1, 1'b0);
		add_cycle(KIND_WRITE, ADDR_WIDTH'(UNLOCK_ADDR2), UNLOCK_DATA2, 1'b0);
		add_cycle(KIND_WRITE, ADDR_WIDTH'(UNLOCK_ADDR1), cmd, 1'b0);
	endtask

	task automatic finish_command(input logic ok);
		add_cycle(KIND_DONE, '0, 8'h00, ok);
		phase_now = PH_IDLE;
	endtask

	function automatic logic [REG_WIDTH-1:0] poll_ceiling();
		if (cmd_now == OP_PROG) return limits[CFG_PROG_POLL];
		if (cmd_now == OP_SECTOR) return limits[CFG_SECTOR_POLL];
		return limits[CFG_CHIP_POLL];
	endfunction

	function automatic logic [REG_WIDTH-1:0] ok_ceiling();
		if (cmd_now == OP_PROG) return limits[CFG_PROG_OK];
		if (cmd_now == OP_SECTOR) return limits[CFG_SECTOR_OK];
		return limits[CFG_CHIP_OK];
	endfunction

	// zero poll limit skips polling and reports at once
	task automatic begin_polling(input logic [ADDR_WIDTH-1:0] a);
		polls = '0;
		if (poll_ceiling() == '0) begin
			finish_command(ok_ceiling() != '0);
		end else begin
			add_cycle(KIND_READ_REQ, a, 8'h00, 1'b0);
			phase_now = PH_POLL;
		end
	endtask

	task automatic plan_bus_cycles(input logic [2:0] op, input logic [ADDR_WIDTH-1:0] a,
			input logic [7:0] d, input logic [7:0] n);
		bus_cycle_t c;
		new_cycles.delete();
		if (op == OP_SAMPLE) begin
			case (phase_now)
				PH_READ: begin
					add_cycle(KIND_DATA, read_ptr, d, 1'b0);
					read_ptr   = read_ptr + ADDR_WIDTH'(1);
					reads_todo = reads_todo - 8'd1;
					if (reads_todo == 8'd0)
						finish_command(1'b1);
					else
						add_cycle(KIND_READ_REQ, read_ptr, 8'h00, 1'b0);
				end
				PH_POLL: begin
					if (d[7] == want_top) begin
						finish_command(polls < ok_ceiling());
					end else begin
						if (polls != 16'hFFFF) polls++;
						if (polls >= poll_ceiling()) finish_command(polls < ok_ceiling());
					end
				end
				PH_ID_MAN: begin
					add_cycle(KIND_DATA, ID_MAN_ADDR, d, 1'b0);
					add_cycle(KIND_READ_REQ, ID_DEV_ADDR, 8'h00, 1'b0);
					phase_now = PH_ID_DEV;
				end
				PH_ID_DEV: begin
					add_cycle(KIND_DATA, ID_DEV_ADDR, d, 1'b0);
					send_unlock(CMD_ID_EXIT);
					finish_command(1'b1);
				end
				default: ;
			endcase
		end else if (op <= OP_ID && phase_now == PH_IDLE) begin
			cmd_now = op;
			case (op)
				OP_READ: begin
					if (n == 8'd0) begin
						finish_command(1'b1);
					end else begin
						read_ptr   = a;
						reads_todo = n;
						add_cycle(KIND_READ_REQ, a, 8'h00, 1'b0);
						phase_now = PH_READ;
					end
				end
				OP_PROG: begin
					send_unlock(CMD_PROGRAM);
					add_cycle(KIND_WRITE, a, d, 1'b0);
					want_top = d[7];
					begin_polling(a);
				end
				OP_SECTOR: begin
					send_unlock(CMD_ERASE);
					add_cycle(KIND_WRITE, ADDR_WIDTH'(UNLOCK_ADDR1), UNLOCK_DATA1, 1'b0);
					add_cycle(KIND_WRITE, ADDR_WIDTH'(UNLOCK_ADDR2), UNLOCK_DATA2, 1'b0);
					add_cycle(KIND_WRITE, a, CMD_SECTOR, 1'b0);
					want_top = 1'b1;
					begin_polling(a);
				end
				OP_CHIP: begin
					send_unlock(CMD_ERASE);
					add_cycle(KIND_WRITE, ADDR_WIDTH'(UNLOCK_ADDR1), UNLOCK_DATA1, 1'b0);
					add_cycle(KIND_WRITE, ADDR_WIDTH'(UNLOCK_ADDR2), UNLOCK_DATA2, 1'b0);
					add_cycle(KIND_WRITE, ADDR_WIDTH'(UNLOCK_ADDR1), CMD_CHIP, 1'b0);
					want_top = 1'b1;
					begin_polling(ADDR_WIDTH'(UNLOCK_ADDR1));
				end
				default: begin
					send_unlock(CMD_ID_ENTRY);
					add_cycle(KIND_READ_REQ, ID_MAN_ADDR, 8'h00, 1'b0);
					phase_now = PH_ID_MAN;
				end
			endcase
		end
		// final cycle of the transaction carries the last flag
		foreach (new_cycles[i]) begin
			c     = new_cycles[i];
			c.fin = (i == new_cycles.size() - 1);
			owed_cycles.push_back(c);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_cycles.delete();
			foreach (limits[i]) limits[i] = REG_RESET[i];
			phase_now   = PH_IDLE;
			cmd_now     = OP_READ;
			want_top    = 1'b0;
			polls       = '0;
			read_ptr    = '0;
			reads_todo  = '0;
			mismatches  = 0;
			compared    = 0;
		end else begin
			if (cfg_write && cfg_index < NUM_REGS) limits[cfg_index] = cfg_data;
			if (push && !full) plan_bus_cycles(operation, address, data_byte, byte_count);
			if (pop && !empty) begin
				if (owed_cycles.size() == 0) begin
					report_mismatch("result with nothing owed", cycle_kind, 0);
				end else begin
					head = owed_cycles.pop_front();
					compared++;
					if (cycle_kind !== head.kind) report_mismatch("cycle_kind", cycle_kind, head.kind);
					if (bus_address !== head.addr) report_mismatch("bus_address", bus_address, head.addr);
					if (bus_data !== head.data) report_mismatch("bus_data", bus_data, head.data);
					if (success !== head.ok) report_mismatch("success", success, head.ok);
					if (last !== head.fin) report_mismatch("last", last, head.fin);
				end
			end
		end
		outstanding = owed_cycles.size();
		busy        = (phase_now != PH_IDLE);
	end

endmodule

// File: bench/parallel_flash_command_sequencer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// parallel_flash_command_sequencer_test: regression for the flash sequencer
// Drives a directed set of commands and samples, then random command and
// sample streams under six limit settings with random gaps on both sides, a
// long consumer stall and a gap-free stretch; the checker beside the block
// predicts and compares every bus cycle.
// ----------------------------------------------------------------------------
module parallel_flash_command_sequencer_test;
	import pfcs_pkg::*;

	localparam int AW              = ADDR_WIDTH_DEF;
	localparam int HALF_PERIOD     = 10;
	localparam int RESET_CYCLES    = 8;
	localparam int IDLE_PCT        = 28;
	localparam int NOISE_PCT       = 8;
	localparam int MISS_PCT        = 70;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 40;
	localparam int LONG_BURST      = 40;
	localparam int HOLD_CYCLES     = 300;
	localparam int SETTLE_CYCLES   = 40;
	localparam int CYCLE_LIMIT     = 300000;

	// codes the block has no use for
	localparam logic [2:0] OP_UNUSED_A = 3'd6;
	localparam logic [2:0] OP_UNUSED_B = 3'd7;
	localparam logic [AW-1:0] TOP_ADDR = '1;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     cfg_write  = 1'b0;
	logic [CFG_IDX_WIDTH-1:0] cfg_index  = CFG_PROG_POLL;
	logic [REG_WIDTH-1:0]     cfg_data   = '0;
	logic                     push       = 1'b0;
	logic                     full;
	logic [2:0]               operation  = OP_READ;
	logic [AW-1:0]            address    = '0;
	logic [7:0]               data_byte  = '0;
	logic [7:0]               byte_count = '0;
	logic                     empty;
	logic                     pop        = 1'b0;
	logic [1:0]               cycle_kind;
	logic [AW-1:0]            bus_address;
	logic [7:0]               bus_data;
	logic                     success;
	logic                     last;

	int   mismatches;
	int   outstanding;
	int   compared;
	logic busy;

	// stimulus bookkeeping
	int   cycle_no   = 0;
	int   n_commands = 0;
	int   n_samples  = 0;
	int   n_settings = 0;
	int   hold_left  = 0;
	bit   hold_asked = 1'b0;
	bit   hold_taken = 1'b0;
	bit   calm       = 1'b0;
	logic [2:0] cur_cmd  = OP_READ;
	logic       cur_want = 1'b0;

	parallel_flash_command_sequencer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.operation   (operation),
		.address     (address),
		.data_byte   (data_byte),
		.byte_count  (byte_count),
		.empty       (empty),
		.pop         (pop),
		.cycle_kind  (cycle_kind),
		.bus_address (bus_address),
		.bus_data    (bus_data),
		.success     (success),
		.last        (last)
	);

	pfcs_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.operation   (operation),
		.address     (address),
		.data_byte   (data_byte),
		.byte_count  (byte_count),
		.empty       (empty),
		.pop         (pop),
		.cycle_kind  (cycle_kind),
		.bus_address (bus_address),
		.bus_data    (bus_data),
		.success     (success),
		.last        (last),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.compared    (compared),
		.busy        (busy)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: random pop gaps, one long stall on request, none when calm
	always @(negedge clk) begin
		if (hold_asked && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (calm) begin
			pop <= 1'b1;
		end else begin
			pop <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// one transaction on the command side, entered and left at a falling edge;
	// push stays high into the next transaction unless a gap is drawn
	task automatic offer(input logic [2:0] op, input logic [AW-1:0] a,
			input logic [7:0] d, input logic [7:0] n);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push       <= 1'b1;
		operation  <= op;
		address    <= a;
		data_byte  <= d;
		byte_count <= n;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [REG_WIDTH-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
	endtask

	// feed random samples until no command is under way, then let the
	// results drain and the job queue run dry before touching the limits
	task automatic finish_commands();
		while (busy) offer(OP_SAMPLE, AW'($urandom), 8'($urandom), 8'($urandom));
		push <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int            ph;
		int            useful;
		int            target;
		int            roll;
		logic [2:0]    op;
		logic [AW-1:0] a;
		logic [7:0]    d;
		logic [7:0]    n;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ---- directed part, reset limits ----
		// burst that wraps past the top address, with extreme sample bytes
		offer(OP_READ, TOP_ADDR - AW'(1), 8'h00, 8'd3);
		offer(OP_SAMPLE, '0, 8'h00, 8'h00);
		offer(OP_SAMPLE, TOP_ADDR, 8'hFF, 8'hFF);
		offer(OP_SAMPLE, '0, 8'h5A, 8'h00);
		// empty burst answers done straight away
		offer(OP_READ, TOP_ADDR, 8'hFF, 8'h00);
		// sample while idle and both unused codes are swallowed
		offer(OP_SAMPLE, TOP_ADDR, 8'hFF, 8'hFF);
		offer(OP_UNUSED_A, TOP_ADDR, 8'hFF, 8'hFF);
		offer(OP_UNUSED_B, '0, 8'h00, 8'h00);
		// program a byte with bit 7 set; a command mid-poll is ignored
		offer(OP_PROG, TOP_ADDR, 8'hFF, 8'hFF);
		offer(OP_READ, '0, 8'h00, 8'd4);
		offer(OP_SAMPLE, '0, 8'h00, 8'h00);
		offer(OP_SAMPLE, '0, 8'h80, 8'h00);
		// sector erase completes on the first poll
		offer(OP_SECTOR, 19'h2AAAA, 8'h00, 8'h00);
		offer(OP_SAMPLE, '0, 8'hFF, 8'h00);
		// chip erase with one miss and a stray command in between
		offer(OP_CHIP, 19'h55555, 8'h33, 8'h01);
		offer(OP_SAMPLE, '0, 8'h7F, 8'h00);
		offer(OP_ID, '0, 8'h00, 8'h00);
		offer(OP_SAMPLE, '0, 8'h80, 8'h00);
		// read id: manufacturer byte, device byte, then the exit sequence
		offer(OP_ID, 19'h12345, 8'hC3, 8'h10);
		offer(OP_SAMPLE, '0, 8'hBF, 8'h00);
		offer(OP_SAMPLE, '0, 8'h01, 8'h00);
		// program a byte with bit 7 clear, so a high bit 7 counts as a miss
		offer(OP_PROG, 19'h55555, 8'h00, 8'h00);
		offer(OP_SAMPLE, '0, 8'h80, 8'h00);
		offer(OP_SAMPLE, '0, 8'h7F, 8'h00);
		finish_commands();

		// ---- random part, one limit setting per phase ----
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				1: begin
					// polling skipped everywhere; ok limit decides the verdict
					write_reg(CFG_PROG_POLL, 16'd0);
					write_reg(CFG_PROG_OK, 16'd0);
					write_reg(CFG_SECTOR_POLL, 16'd0);
					write_reg(CFG_SECTOR_OK, 16'hFFFF);
					write_reg(CFG_CHIP_POLL, 16'd0);
					write_reg(CFG_CHIP_OK, 16'd1);
				end
				2: begin
					// tight limits so that timeouts and late successes show up
					write_reg(CFG_PROG_POLL, 16'd3);
					write_reg(CFG_PROG_OK, 16'd2);
					write_reg(CFG_SECTOR_POLL, 16'd5);
					write_reg(CFG_SECTOR_OK, 16'd5);
					write_reg(CFG_CHIP_POLL, 16'd1);
					write_reg(CFG_CHIP_OK, 16'd0);
				end
				3: begin
					write_reg(CFG_PROG_POLL, 16'hFFFF);
					write_reg(CFG_PROG_OK, 16'hFFFF);
					write_reg(CFG_SECTOR_POLL, 16'hFFFF);
					write_reg(CFG_SECTOR_OK, 16'hFFFF);
					write_reg(CFG_CHIP_POLL, 16'hFFFF);
					write_reg(CFG_CHIP_OK, 16'hFFFF);
				end
				4: begin
					write_reg(CFG_PROG_POLL, REG_WIDTH'($urandom_range(6)));
					write_reg(CFG_PROG_OK, REG_WIDTH'($urandom_range(6)));
					write_reg(CFG_SECTOR_POLL, REG_WIDTH'($urandom_range(6)));
					write_reg(CFG_SECTOR_OK, REG_WIDTH'($urandom_range(6)));
					write_reg(CFG_CHIP_POLL, REG_WIDTH'($urandom_range(6)));
					write_reg(CFG_CHIP_OK, REG_WIDTH'($urandom_range(6)));
				end
				5: begin
					write_reg(CFG_PROG_POLL, REG_WIDTH'($urandom));
					write_reg(CFG_PROG_OK, REG_WIDTH'($urandom));
					write_reg(CFG_SECTOR_POLL, REG_WIDTH'($urandom));
					write_reg(CFG_SECTOR_OK, REG_WIDTH'($urandom));
					write_reg(CFG_CHIP_POLL, REG_WIDTH'($urandom));
					write_reg(CFG_CHIP_OK, REG_WIDTH'($urandom));
				end
				default: ;
			endcase
			cfg_write <= 1'b0;
			n_settings++;
			calm = (ph == 3);
			// long consumer stall while commands keep arriving
			if (ph == 2) hold_asked = 1'b1;

			useful = 0;
			target = ITEMS_PER_PHASE;
			if (ph == 0) begin
				// long burst, wrapping past the top address
				offer(OP_READ, TOP_ADDR - AW'(4), 8'h00, 8'(LONG_BURST));
				cur_cmd = OP_READ;
				n_commands++;
				target = ITEMS_PER_PHASE + LONG_BURST;
			end

			while (useful < target) begin
				a    = AW'($urandom);
				d    = 8'($urandom);
				roll = $urandom_range(99);
				if (roll < 5)
					n = 8'd0;
				else if (roll < 20)
					n = 8'($urandom_range(255));
				else
					n = 8'($urandom_range(4, 1));
				roll = $urandom_range(99);
				if (roll < NOISE_PCT) begin
					// noise the block must swallow without results
					if (roll < NOISE_PCT / 2)
						op = $urandom_range(1) ? OP_UNUSED_A : OP_UNUSED_B;
					else if (busy)
						op = 3'($urandom_range(OP_ID));
					else
						op = OP_SAMPLE;
					offer(op, a, d, n);
				end else if (!busy) begin
					op       = 3'($urandom_range(OP_ID));
					cur_cmd  = op;
					cur_want = (op == OP_PROG) ? d[7] : 1'b1;
					offer(op, a, d, n);
					n_commands++;
					useful++;
				end else begin
					// while polling, lean towards misses so the limits get reached
					if (cur_cmd == OP_PROG || cur_cmd == OP_SECTOR || cur_cmd == OP_CHIP)
						d[7] = ($urandom_range(99) < MISS_PCT) ? ~cur_want : cur_want;
					offer(OP_SAMPLE, a, d, n);
					n_samples++;
					useful++;
				end
			end
			finish_commands();
		end

		$display("run covered %0d random commands and %0d samples under %0d limit settings",
			n_commands, n_samples, n_settings);
		$display("%0d bus cycles compared, %0d mismatches, one long result stall",
			compared, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
src/pfcs_pkg.sv
src/pfcs_front.sv
src/pfcs_queue.sv
src/pfcs_back.sv
src/parallel_flash_command_sequencer.sv
bench/pfcs_checker.sv
bench/parallel_flash_command_sequencer_test.sv
